// ===== rtl/teq_pkg.sv =====
// Package: shared types and constants for the timer expiry queue.
`default_nettype none
package teq_pkg;
  localparam int SLOTS_DEF = 16;
  localparam logic [39:0] MAX_WAIT_RST = 40'd1000000;
  localparam logic [39:0] MIN_WAIT_RST = 40'd1;

  typedef enum logic [2:0] {
    OP_CREATE = 3'd0, OP_CANCEL = 3'd1, OP_POLL = 3'd2, OP_RESOLVE = 3'd3, OP_FLUSH = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    K_CREATED = 3'd0, K_CANCELLED = 3'd1, K_EXPIRED = 3'd2, K_POLL_DONE = 3'd3,
    K_RESOLVED = 3'd4, K_FLUSHED = 3'd5
  } kind_t;

  typedef enum logic [1:0] { C_FREE = 2'd0, C_ARMED = 2'd1, C_PENDING = 2'd2 } cond_t;

  typedef enum logic [0:0] { CFG_MAX = 1'b0, CFG_MIN = 1'b1 } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_CREATE, S_CANCEL, S_RESOLVE, S_POLL_HEAD, S_POLL_CHK, S_POLL_POP,
    S_POLL_DONE, S_FLUSH, S_ENQ_RANK, S_ENQ_SHIFT, S_OUT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic latch_in;      // capture input transaction
    logic clr_scan;      // restart slot walk
    logic step;          // advance slot walk
    logic scan_find;     // search matches in walk
    logic scan_count;    // count positions for enqueue
    logic do_create;
    logic do_cancel;
    logic do_pend;       // mark head pending
    logic do_free;       // free target slot
    logic do_enq;        // insert target at counted position
    logic do_flush;
    logic set_out;       // load output register
    kind_t out_kind;
    logic out_fail;
    logic out_last;
    logic out_clr;       // output taken
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_end;
    logic found;
    logic hit;
    logic head_due;
    logic rearm;
    logic out_full;
  } stat_t;
endpackage
`default_nettype wire

// ===== rtl/teq_ctrl.sv =====
// Controller: sequences the slot walks for each operation.
`default_nettype none
module teq_ctrl
  import teq_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire logic [2:0] in_op,
  input  wire logic  out_ready,
  input  stat_t      st,
  output cmd_t       cmd
);
  state_t state_r, state_nxt;
  op_t op_r;
  state_t ret_r, ret_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r <= OP_CREATE;
      ret_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
      ret_r <= ret_nxt;
      if (in_valid && in_ready) op_r <= op_t'(in_op);
    end
  end

  assign in_ready = (state_r == S_IDLE) && !st.out_full;

  always_comb begin
    state_nxt = state_r;
    ret_nxt = ret_r;
    unique case (state_r)
      S_IDLE:
        if (in_valid && in_ready) begin
          if (in_op == OP_POLL) state_nxt = S_POLL_HEAD;
          else if (in_op == OP_FLUSH) state_nxt = S_FLUSH;
          else if (in_op <= OP_RESOLVE) state_nxt = S_SCAN;
        end
      S_SCAN:
        if (st.scan_end) begin
          unique case (op_r)
            OP_CREATE: state_nxt = (st.found || st.hit) ? S_ENQ_RANK : S_CREATE;
            OP_CANCEL: state_nxt = S_CANCEL;
            default:   state_nxt = ((st.found || st.hit) && st.rearm) ? S_ENQ_RANK
                                                                      : S_RESOLVE;
          endcase
        end
      S_ENQ_RANK: if (st.scan_end) state_nxt = S_ENQ_SHIFT;
      S_ENQ_SHIFT:
        state_nxt = (op_r == OP_CREATE) ? S_CREATE : S_RESOLVE;
      S_CREATE, S_CANCEL, S_RESOLVE, S_FLUSH, S_POLL_DONE: state_nxt = S_OUT;
      S_POLL_HEAD: if (st.scan_end) state_nxt = S_POLL_CHK;
      S_POLL_CHK: state_nxt = st.head_due ? S_POLL_POP : S_POLL_DONE;
      S_POLL_POP: state_nxt = S_OUT;
      S_OUT:
        if (!st.out_full) state_nxt = (op_r == OP_POLL && ret_r == S_POLL_HEAD) ?
                                      S_POLL_HEAD : S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
    if (state_r == S_POLL_POP) ret_nxt = S_POLL_HEAD;
    else if (state_r == S_POLL_DONE || state_r == S_IDLE) ret_nxt = S_IDLE;
  end

  always_comb begin
    cmd = '0;
    cmd.out_kind = K_CREATED;
    cmd.out_clr = out_ready;
    unique case (state_r)
      S_IDLE: begin
        cmd.latch_in = in_valid && in_ready;
        cmd.clr_scan = 1'b1;
      end
      S_SCAN: begin
        cmd.step = 1'b1;
        cmd.scan_find = 1'b1;
        if (st.scan_end) cmd.clr_scan = 1'b1;
      end
      S_ENQ_RANK: begin
        cmd.step = 1'b1;
        cmd.scan_count = 1'b1;
      end
      S_ENQ_SHIFT: cmd.do_enq = 1'b1;
      S_CREATE: begin
        cmd.do_create = st.found;
        cmd.set_out = 1'b1;
        cmd.out_kind = K_CREATED;
        cmd.out_fail = !st.found;
        cmd.out_last = 1'b1;
      end
      S_CANCEL: begin
        cmd.do_cancel = st.found;
        cmd.set_out = 1'b1;
        cmd.out_kind = K_CANCELLED;
        cmd.out_fail = !st.found;
        cmd.out_last = 1'b1;
      end
      S_RESOLVE: begin
        cmd.do_free = st.found && !st.rearm;
        cmd.set_out = 1'b1;
        cmd.out_kind = K_RESOLVED;
        cmd.out_fail = !st.found;
        cmd.out_last = 1'b1;
      end
      S_FLUSH: begin
        cmd.do_flush = 1'b1;
        cmd.set_out = 1'b1;
        cmd.out_kind = K_FLUSHED;
        cmd.out_last = 1'b1;
      end
      S_POLL_HEAD: begin
        cmd.step = 1'b1;
        cmd.scan_find = 1'b1;
      end
      S_POLL_CHK: ;
      S_POLL_POP: begin
        cmd.do_pend = 1'b1;
        cmd.set_out = 1'b1;
        cmd.out_kind = K_EXPIRED;
      end
      S_POLL_DONE: begin
        cmd.set_out = 1'b1;
        cmd.out_kind = K_POLL_DONE;
        cmd.out_last = 1'b1;
      end
      S_OUT: if (!st.out_full) cmd.clr_scan = 1'b1;
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// ===== rtl/teq_dp.sv =====
// Datapath: slot store, slot walk, rank update, wait clamp and output register.
`default_nettype none
module teq_dp
  import teq_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  cmd_t             cmd,
  output stat_t            st,
  input  wire logic [2:0]  in_op,
  input  wire logic [62:0] in_now_us,
  input  wire logic [39:0] in_timeout_us,
  input  wire logic [31:0] in_payload,
  input  wire logic [30:0] in_target_id,
  input  wire logic        in_rearm,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_index,
  input  wire logic [39:0] cfg_data,
  output logic             out_valid,
  output logic [2:0]       out_kind,
  output logic             out_status,
  output logic [30:0]      out_timer_id,
  output logic [31:0]      out_payload_out,
  output logic [39:0]      out_wait_us,
  output logic             out_last
);
  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);

  logic [63:0] exp_r [SLOTS];
  logic [39:0] per_r [SLOTS];
  logic [31:0] pay_r [SLOTS];
  logic [30:0] id_r  [SLOTS];
  cond_t       cond_r [SLOTS];
  logic [IW-1:0] rank_r [SLOTS];

  logic [30:0] next_id_r;
  logic [62:0] lpt_r;
  logic [39:0] max_r, min_r;
  op_t op_r;
  logic [62:0] now_r;
  logic [39:0] tmo_r;
  logic [31:0] pin_r;
  logic [30:0] tid_r;
  logic rearm_r;

  logic [IW-1:0] idx_r;
  logic found_r;
  logic [IW-1:0] sel_r;
  logic [CW-1:0] pos_r;
  logic [63:0] enq_exp;

  logic [IW-1:0] idx;
  logic [30:0] nid;
  logic hit;
  logic [63:0] rem;
  logic [39:0] wait_v;

  assign idx = idx_r;
  assign st.scan_end = (idx_r == IW'(SLOTS - 1));
  assign st.found = found_r;
  assign st.hit = hit;
  assign st.rearm = rearm_r;
  assign st.head_due = found_r && (exp_r[sel_r] <= {1'b0, now_r});
  assign st.out_full = out_valid;
  assign enq_exp = (op_r == OP_CREATE) ? ({1'b0, now_r} + 64'(tmo_r))
                                        : ({1'b0, lpt_r} + 64'(per_r[sel_r]));
  assign nid = (next_id_r == 31'h7fffffff) ? 31'd1 : next_id_r + 31'd1;

  always_comb begin
    hit = 1'b0;
    unique case (op_r)
      OP_CREATE:  hit = !found_r && cond_r[idx] == C_FREE;
      OP_CANCEL:  hit = tid_r != '0 && cond_r[idx] == C_ARMED && id_r[idx] == tid_r &&
                        (!found_r || rank_r[idx] < rank_r[sel_r]);
      OP_RESOLVE: hit = !found_r && tid_r != '0 && cond_r[idx] == C_PENDING &&
                        id_r[idx] == tid_r;
      OP_POLL:    hit = cond_r[idx] == C_ARMED && rank_r[idx] == '0;
      default:    hit = 1'b0;
    endcase
  end

  always_comb begin
    rem = exp_r[sel_r] - {1'b0, now_r};
    if (!found_r) wait_v = max_r;
    else if (rem > 64'(max_r)) wait_v = max_r;
    else if (rem <= 64'(min_r)) wait_v = min_r;
    else wait_v = rem[39:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < SLOTS; j++) begin
        cond_r[j] <= C_FREE;
        rank_r[j] <= '0;
      end
      next_id_r <= '0;
      lpt_r <= '0;
      max_r <= MAX_WAIT_RST;
      min_r <= MIN_WAIT_RST;
      out_valid <= 1'b0;
      idx_r <= '0;
      found_r <= 1'b0;
      pos_r <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_MAX: max_r <= cfg_data;
          CFG_MIN: min_r <= cfg_data;
        endcase
      end
      if (cmd.latch_in) begin
        op_r <= op_t'(in_op);
        now_r <= in_now_us;
        tmo_r <= in_timeout_us;
        pin_r <= in_payload;
        tid_r <= in_target_id;
        rearm_r <= in_rearm;
        if (op_t'(in_op) == OP_POLL) lpt_r <= in_now_us;
      end
      if (cmd.clr_scan) begin
        idx_r <= '0;
        pos_r <= '0;
        if (!cmd.step) found_r <= 1'b0;
      end else if (cmd.step) begin
        idx_r <= st.scan_end ? '0 : idx_r + IW'(1);
      end
      if (cmd.scan_find && hit) begin
        found_r <= 1'b1;
        sel_r <= idx;
      end
      if (cmd.scan_count && cond_r[idx] == C_ARMED && exp_r[idx] <= enq_exp)
        pos_r <= pos_r + CW'(1);
      if (cmd.do_enq) begin
        for (int j = 0; j < SLOTS; j++)
          if (cond_r[j] == C_ARMED && CW'(rank_r[j]) >= pos_r)
            rank_r[j] <= rank_r[j] + IW'(1);
        rank_r[sel_r] <= pos_r[IW-1:0];
        cond_r[sel_r] <= C_ARMED;
        exp_r[sel_r] <= enq_exp;
      end
      if (cmd.do_create) begin
        next_id_r <= nid;
        per_r[sel_r] <= tmo_r;
        pay_r[sel_r] <= pin_r;
        id_r[sel_r] <= nid;
      end
      if (cmd.do_cancel || cmd.do_pend) begin
        for (int j = 0; j < SLOTS; j++)
          if (IW'(j) != sel_r && cond_r[j] == C_ARMED && rank_r[j] > rank_r[sel_r])
            rank_r[j] <= rank_r[j] - IW'(1);
        rank_r[sel_r] <= '0;
        cond_r[sel_r] <= cmd.do_pend ? C_PENDING : C_FREE;
      end
      if (cmd.do_free) cond_r[sel_r] <= C_FREE;
      if (cmd.do_flush)
        for (int j = 0; j < SLOTS; j++) begin
          cond_r[j] <= C_FREE;
          rank_r[j] <= '0;
        end
      if (cmd.set_out) out_valid <= 1'b1;
      else if (cmd.out_clr) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.set_out) begin
      out_kind <= cmd.out_kind;
      out_status <= cmd.out_fail;
      out_last <= cmd.out_last;
      out_wait_us <= (cmd.out_kind == K_POLL_DONE) ? wait_v : '0;
      out_payload_out <= (cmd.out_fail || cmd.out_kind == K_CREATED ||
                          cmd.out_kind == K_POLL_DONE || cmd.out_kind == K_FLUSHED)
                         ? '0 : pay_r[sel_r];
      unique case (cmd.out_kind)
        K_CREATED:   out_timer_id <= cmd.out_fail ? '0 : nid;
        K_EXPIRED:   out_timer_id <= id_r[sel_r];
        K_CANCELLED, K_RESOLVED: out_timer_id <= tid_r;
        default:     out_timer_id <= '0;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== rtl/timer_expiry_queue.sv =====
// Top level: sorted timer queue with create, cancel, poll, resolve and flush.
//
// Usage:
//   Input transactions (in_*) carry an op and its operands; each is taken when
//   in_valid and in_ready are high together. Results leave on out_* one
//   transaction at a time; out_last marks the final result of an input item.
//   Poll yields one expired result per due timer then a poll-done result.
//   Config writes (cfg_index 0 max wait, 1 min wait) are taken every cycle.
// Sequence (each walk visits the SLOTS entries one per cycle):
//   Create, cancel, resolve: one walk over the slots, then the result. A
//   successful create or a re-arm adds a ranking walk and an insert step
//   before the result.
//   Poll walks for the head once per result. Flush: no walk before its result.
//   The next input is taken after the final result is taken.
// Reset: rst_n synchronous, empties the queue and restores wait limits.
// Stall: one result register; while it is full no new item is taken and the
//   next walk waits until out_ready takes the result.
`default_nettype none
module timer_expiry_queue
  import teq_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_op,
  input  wire logic [62:0] in_now_us,
  input  wire logic [39:0] in_timeout_us,
  input  wire logic [31:0] in_payload,
  input  wire logic [30:0] in_target_id,
  input  wire logic        in_rearm,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_kind,
  output logic             out_status,
  output logic [30:0]      out_timer_id,
  output logic [31:0]      out_payload_out,
  output logic [39:0]      out_wait_us,
  output logic             out_last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [39:0] cfg_data
);
  cmd_t  cmd;
  stat_t st;

  assign cfg_ready = 1'b1;

  teq_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .in_op, .out_ready, .st, .cmd
  );

  teq_dp #(.SLOTS(SLOTS)) u_dp (
    .clk, .rst_n, .cmd, .st, .in_op, .in_now_us, .in_timeout_us, .in_payload,
    .in_target_id, .in_rearm, .cfg_valid, .cfg_index, .cfg_data,
    .out_valid, .out_kind, .out_status, .out_timer_id, .out_payload_out,
    .out_wait_us, .out_last
  );
endmodule
`default_nettype wire

// ===== tb/sv/tb_timer_expiry_queue.sv =====
// Testbench for the timer expiry queue: a predicting scoreboard, directed items and random traffic.
`timescale 1ns / 100ps
module tb_timer_expiry_queue
  import teq_pkg::*;
;

  localparam int NSLOT = 16;
  localparam int SETTLE = 2 * NSLOT + 40;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct {
    kind_t       kind;
    bit          status;
    bit [30:0]   timer_id;
    bit [31:0]   payload;
    bit [39:0]   wait_us;
    bit          last;
  } timer_result_t;

  class timer_scoreboard;
    bit [63:0]     expiry[NSLOT];
    bit [39:0]     period[NSLOT];
    bit [31:0]     payload[NSLOT];
    bit [30:0]     ident[NSLOT];
    cond_t         cond[NSLOT];
    int            rank[NSLOT];
    bit [30:0]     next_ident;
    bit [62:0]     poll_time;
    bit [39:0]     max_wait;
    bit [39:0]     min_wait;
    timer_result_t awaited[$];
    int            errors;
    int            checked;
    int            items;

    function void clear_all();
      for (int j = 0; j < NSLOT; j++) begin
        cond[j] = C_FREE;
        rank[j] = 0;
      end
      next_ident = 0;
      poll_time = 0;
      max_wait = MAX_WAIT_RST;
      min_wait = MIN_WAIT_RST;
    endfunction

    function void set_reg(cfg_idx_t idx, bit [39:0] val);
      if (idx == CFG_MAX) max_wait = val;
      else min_wait = val;
    endfunction

    function void push(kind_t k, bit st, bit [30:0] id, bit [31:0] pay, bit [39:0] w);
      timer_result_t r;
      r.kind = k;
      r.status = st;
      r.timer_id = id;
      r.payload = pay;
      r.wait_us = w;
      r.last = 0;
      awaited.push_back(r);
    endfunction

    function void insert_sorted(int s, bit [63:0] t);
      int pos;
      pos = 0;
      for (int j = 0; j < NSLOT; j++)
        if (cond[j] == C_ARMED && expiry[j] <= t) pos++;
      for (int j = 0; j < NSLOT; j++)
        if (cond[j] == C_ARMED && rank[j] >= pos) rank[j]++;
      expiry[s] = t;
      cond[s] = C_ARMED;
      rank[s] = pos;
    endfunction

    function void unlink(int s);
      for (int j = 0; j < NSLOT; j++)
        if (j != s && cond[j] == C_ARMED && rank[j] > rank[s]) rank[j]--;
      rank[s] = 0;
    endfunction

    function int head();
      for (int j = 0; j < NSLOT; j++)
        if (cond[j] == C_ARMED && rank[j] == 0) return j;
      return -1;
    endfunction

    function int pick_id(cond_t c);
      int hits[$];
      for (int j = 0; j < NSLOT; j++)
        if (cond[j] == c) hits.push_back(j);
      if (hits.size() == 0) return 0;
      return ident[hits[$urandom_range(0, hits.size() - 1)]];
    endfunction

    function void note_input(bit [2:0] op, bit [62:0] now, bit [39:0] tmo, bit [31:0] pay,
                             bit [30:0] tid, bit rearm);
      int s;
      int before_n;
      bit [63:0] rem;
      bit [39:0] w;
      s = -1;
      before_n = awaited.size();
      case (op)
        OP_CREATE: begin
          for (int j = 0; j < NSLOT; j++)
            if (cond[j] == C_FREE) begin
              s = j;
              break;
            end
          if (s < 0) push(K_CREATED, 1, 0, 0, 0);
          else begin
            next_ident = next_ident + 31'd1;
            if (next_ident == 0) next_ident = 1;
            period[s] = tmo;
            payload[s] = pay;
            ident[s] = next_ident;
            insert_sorted(s, {1'b0, now} + {24'd0, tmo});
            push(K_CREATED, 0, next_ident, 0, 0);
          end
        end
        OP_CANCEL: begin
          if (tid != 0)
            for (int j = 0; j < NSLOT; j++)
              if (cond[j] == C_ARMED && ident[j] == tid && (s < 0 || rank[j] < rank[s])) s = j;
          if (s < 0) push(K_CANCELLED, 1, tid, 0, 0);
          else begin
            unlink(s);
            cond[s] = C_FREE;
            push(K_CANCELLED, 0, tid, payload[s], 0);
          end
        end
        OP_POLL: begin
          w = max_wait;
          poll_time = now;
          for (int j = 0; j < NSLOT; j++) begin
            s = head();
            if (s < 0 || expiry[s] > {1'b0, now}) break;
            unlink(s);
            cond[s] = C_PENDING;
            push(K_EXPIRED, 0, ident[s], payload[s], 0);
          end
          s = head();
          if (s >= 0) begin
            rem = expiry[s] - {1'b0, now};
            if (rem > {24'd0, max_wait}) w = max_wait;
            else if (rem <= {24'd0, min_wait}) w = min_wait;
            else w = rem[39:0];
          end
          push(K_POLL_DONE, 0, 0, 0, w);
        end
        OP_RESOLVE: begin
          if (tid != 0)
            for (int j = 0; j < NSLOT; j++)
              if (cond[j] == C_PENDING && ident[j] == tid) begin
                s = j;
                break;
              end
          if (s < 0) push(K_RESOLVED, 1, tid, 0, 0);
          else begin
            if (rearm) insert_sorted(s, {1'b0, poll_time} + {24'd0, period[s]});
            else cond[s] = C_FREE;
            push(K_RESOLVED, 0, tid, payload[s], 0);
          end
        end
        OP_FLUSH: begin
          for (int j = 0; j < NSLOT; j++) begin
            cond[j] = C_FREE;
            rank[j] = 0;
          end
          push(K_FLUSHED, 0, 0, 0, 0);
        end
        default: ;
      endcase
      if (awaited.size() > before_n) begin
        awaited[awaited.size() - 1].last = 1;
        items++;
      end
    endfunction

    function void check_result(bit [2:0] k, bit st, bit [30:0] id, bit [31:0] pay,
                               bit [39:0] w, bit lst);
      timer_result_t e;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result kind %0d id %0d", $time, k, id);
        errors++;
        return;
      end
      e = awaited.pop_front();
      checked++;
      if (k != e.kind) begin
        $display("%0t: kind expected %0d actual %0d", $time, e.kind, k);
        errors++;
      end
      if (st != e.status) begin
        $display("%0t: status expected %0d actual %0d", $time, e.status, st);
        errors++;
      end
      if (id != e.timer_id) begin
        $display("%0t: timer_id expected %0d actual %0d", $time, e.timer_id, id);
        errors++;
      end
      if (pay != e.payload) begin
        $display("%0t: payload expected %h actual %h", $time, e.payload, pay);
        errors++;
      end
      if (w != e.wait_us) begin
        $display("%0t: wait_us expected %0d actual %0d", $time, e.wait_us, w);
        errors++;
      end
      if (lst != e.last) begin
        $display("%0t: last expected %0d actual %0d", $time, e.last, lst);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  in_op;
  logic [62:0] in_now_us;
  logic [39:0] in_timeout_us;
  logic [31:0] in_payload;
  logic [30:0] in_target_id;
  logic        in_rearm;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  out_kind;
  logic        out_status;
  logic [30:0] out_timer_id;
  logic [31:0] out_payload_out;
  logic [39:0] out_wait_us;
  logic        out_last;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [39:0] cfg_data;

  timer_scoreboard sb;
  bit          calm;
  bit          hold_go;
  int          stall_left;
  int          cycles;
  bit [62:0]   clock_us;

  timer_expiry_queue dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_op(in_op), .in_now_us(in_now_us),
    .in_timeout_us(in_timeout_us), .in_payload(in_payload), .in_target_id(in_target_id),
    .in_rearm(in_rearm),
    .out_valid(out_valid), .out_ready(out_ready), .out_kind(out_kind),
    .out_status(out_status), .out_timer_id(out_timer_id), .out_payload_out(out_payload_out),
    .out_wait_us(out_wait_us), .out_last(out_last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_kind, out_status, out_timer_id, out_payload_out, out_wait_us, out_last);
    if (hold_go) begin
      hold_go = 0;
      stall_left = 400;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(0, 99) >= 10);
    end
  end

  task automatic send(bit [2:0] op, bit [62:0] now, bit [39:0] tmo, bit [31:0] pay,
                      bit [30:0] tid, bit rearm);
    if (!calm && $urandom_range(0, 99) < 10) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_now_us <= now;
    in_timeout_us <= tmo;
    in_payload <= pay;
    in_target_id <= tid;
    in_rearm <= rearm;
    do @(posedge clk); while (!in_ready);
    sb.note_input(op, now, tmo, pay, tid, rearm);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.awaited.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, bit [39:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_item();
    int pick;
    bit [62:0] now;
    bit [39:0] tmo;
    bit [30:0] tid;
    pick = $urandom_range(0, 99);
    now = clock_us;
    tmo = $urandom_range(0, 3) == 0 ? 40'($urandom_range(0, 8)) : 40'($urandom_range(0, 150));
    if ($urandom_range(0, 29) == 0) tmo = 40'({$urandom, $urandom});
    if ($urandom_range(0, 39) == 0) now = 63'({$urandom, $urandom});
    if (pick < 35) begin
      send(OP_CREATE, now, tmo, $urandom, 31'($urandom), 1'($urandom));
    end else if (pick < 60) begin
      clock_us = clock_us + $urandom_range(0, 60);
      send(OP_POLL, $urandom_range(0, 39) == 0 ? now : clock_us, tmo, $urandom,
           31'($urandom), 1'($urandom));
    end else if (pick < 80) begin
      tid = 31'(sb.pick_id(C_PENDING));
      if ($urandom_range(0, 9) == 0) tid = 31'($urandom);
      send(OP_RESOLVE, now, tmo, $urandom, tid, 1'($urandom));
    end else if (pick < 92) begin
      tid = 31'(sb.pick_id($urandom_range(0, 3) == 0 ? C_PENDING : C_ARMED));
      if ($urandom_range(0, 9) == 0) tid = 31'($urandom);
      send(OP_CANCEL, now, tmo, $urandom, tid, 1'($urandom));
    end else if (pick < 95) begin
      send(OP_FLUSH, now, tmo, $urandom, 31'($urandom), 1'($urandom));
    end else begin
      send(3'($urandom_range(5, 7)), now, tmo, $urandom, 31'($urandom), 1'($urandom));
    end
  endtask

  task automatic random_phase(int count);
    int start;
    start = sb.items;
    while (sb.items - start < count) random_item();
  endtask

  initial begin
    sb = new();
    sb.clear_all();
    clk = 0;
    rst_n = 0;
    in_valid = 0;
    in_op = OP_CREATE;
    in_now_us = 0;
    in_timeout_us = 0;
    in_payload = 0;
    in_target_id = 0;
    in_rearm = 0;
    out_ready = 0;
    cfg_valid = 0;
    cfg_index = CFG_MAX;
    cfg_data = 0;
    calm = 0;
    hold_go = 0;
    stall_left = 0;
    cycles = 0;
    clock_us = 1000;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send(OP_CREATE, 0, 0, 0, 0, 0);
    send(OP_CREATE, {63{1'b1}}, {40{1'b1}}, 32'hFFFF_FFFF, {31{1'b1}}, 1);
    for (int i = 0; i < 14; i++)
      send(OP_CREATE, 100, 40'(i * 7 % 30), $urandom, 0, 0);
    send(OP_CREATE, 200, 5, 32'hA5A5_5A5A, 0, 0);
    send(OP_POLL, 1000, 0, 0, 0, 0);
    send(OP_RESOLVE, 0, 0, 0, 3, 1);
    send(OP_RESOLVE, 0, 0, 0, 4, 0);
    send(OP_RESOLVE, 0, 0, 0, 0, 1);
    send(OP_RESOLVE, 0, 0, 0, 3, 0);
    send(OP_CANCEL, 0, 0, 0, 3, 0);
    send(OP_CANCEL, 0, 0, 0, 0, 0);
    send(OP_CANCEL, 0, 0, 0, 5, 0);
    send(OP_POLL, 0, 0, 0, 0, 0);
    send(3'd5, 0, 0, 0, 0, 0);
    send(OP_FLUSH, 0, 0, 0, 0, 0);
    random_phase(80);
    drain();

    write_reg(CFG_MAX, {40{1'b1}});
    write_reg(CFG_MIN, 1);
    hold_go = 1;
    random_phase(100);
    drain();

    write_reg(CFG_MAX, 50);
    write_reg(CFG_MIN, 20);
    calm = 1;
    random_phase(90);
    calm = 0;
    drain();

    write_reg(CFG_MAX, 10);
    write_reg(CFG_MIN, {40{1'b1}});
    random_phase(80);
    drain();

    $display("Checked %0d results from %0d items over four wait-limit settings,",
             sb.checked, sb.items);
    $display("with a full queue, a long output stall and random handshake gaps.");
    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/teq_pkg.sv
rtl/teq_ctrl.sv
rtl/teq_dp.sv
rtl/timer_expiry_queue.sv
tb/sv/tb_timer_expiry_queue.sv
